// File: sv/cfr_pkg.sv
// cfr_pkg: types, constants and the crc-16/modbus byte update for the frame receiver
// used by every module of the receiver; depends on nothing
package cfr_pkg;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	localparam logic [15:0] RST_FRAME_HEADER     = 16'h55AA;
	localparam logic [15:0] RST_EXPECTED_LENGTH  = 16'd11;
	localparam logic [7:0]  RST_EXPECTED_COMMAND = 8'h02;

	// register indexes on the apb port
	localparam logic [1:0] REG_FRAME_HEADER     = 2'd0;
	localparam logic [1:0] REG_EXPECTED_LENGTH  = 2'd1;
	localparam logic [1:0] REG_EXPECTED_COMMAND = 2'd2;

	// byte positions inside the frame
	localparam logic [3:0] POS_HEADER_LO = 4'd1;
	localparam logic [3:0] POS_LEN_HI    = 4'd2;
	localparam logic [3:0] POS_LEN_LO    = 4'd3;
	localparam logic [3:0] POS_COMMAND   = 4'd4;
	localparam logic [3:0] POS_LEFT_HI   = 4'd5;
	localparam logic [3:0] POS_LEFT_LO   = 4'd6;
	localparam logic [3:0] POS_RIGHT_HI  = 4'd7;
	localparam logic [3:0] POS_RIGHT_LO  = 4'd8;
	localparam logic [3:0] POS_CRC_HI    = 4'd9;
	localparam logic [3:0] POS_CRC_LO    = 4'd10;

	typedef enum logic [1:0] {
		ST_HUNT_FIRST,
		ST_HUNT_SECOND,
		ST_BODY
	} front_state_t;

	// work the back part does for one queued byte
	typedef enum logic [1:0] {
		OP_START,
		OP_ADD,
		OP_CRC_HI,
		OP_FINAL
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [3:0] pos;
		logic [7:0] data;
	} item_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// File: sv/cfr_front.sv
// cfr_front: header hunt and byte classification for the frame receiver
// depends on cfr_pkg; feeds classified items into cfr_queue
module cfr_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           accept,
	input  logic [7:0]     rx_byte,
	input  logic [15:0]    frame_header,
	output logic           push,
	output cfr_pkg::item_t item
);

	cfr_pkg::front_state_t state_q, state_d;
	logic [3:0]            pos_q, pos_d;
	logic [7:0]            hdr_hi, hdr_lo;

	assign hdr_hi = frame_header[15:8];
	assign hdr_lo = frame_header[7:0];

	always_comb begin
		state_d = state_q;
		pos_d   = pos_q;
		case (state_q)
			cfr_pkg::ST_HUNT_SECOND: begin
				if (rx_byte == hdr_lo) begin
					state_d = cfr_pkg::ST_BODY;
					pos_d   = cfr_pkg::POS_LEN_HI;
				end else if (rx_byte == hdr_hi) begin
					state_d = cfr_pkg::ST_HUNT_SECOND;
					pos_d   = cfr_pkg::POS_HEADER_LO;
				end else begin
					state_d = cfr_pkg::ST_HUNT_FIRST;
					pos_d   = 4'd0;
				end
			end
			cfr_pkg::ST_BODY: begin
				if (pos_q <= cfr_pkg::POS_CRC_HI) begin
					pos_d = pos_q + 4'd1;
				end else begin
					state_d = cfr_pkg::ST_HUNT_FIRST;
					pos_d   = 4'd0;
				end
			end
			default: begin
				if (rx_byte == hdr_hi) begin
					state_d = cfr_pkg::ST_HUNT_SECOND;
					pos_d   = cfr_pkg::POS_HEADER_LO;
				end else begin
					state_d = cfr_pkg::ST_HUNT_FIRST;
					pos_d   = 4'd0;
				end
			end
		endcase
	end

	always_comb begin
		push      = 1'b0;
		item.op   = cfr_pkg::OP_ADD;
		item.pos  = pos_q;
		item.data = rx_byte;
		case (state_q)
			cfr_pkg::ST_HUNT_SECOND: begin
				if (rx_byte == hdr_lo) begin
					push    = accept;
					item.op = cfr_pkg::OP_ADD;
				end else if (rx_byte == hdr_hi) begin
					push    = accept;
					item.op = cfr_pkg::OP_START;
				end
			end
			cfr_pkg::ST_BODY: begin
				push = accept;
				if (pos_q < cfr_pkg::POS_CRC_HI) begin
					item.op = cfr_pkg::OP_ADD;
				end else if (pos_q == cfr_pkg::POS_CRC_HI) begin
					item.op = cfr_pkg::OP_CRC_HI;
				end else begin
					item.op = cfr_pkg::OP_FINAL;
				end
			end
			default: begin
				if (rx_byte == hdr_hi) begin
					push    = accept;
					item.op = cfr_pkg::OP_START;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cfr_pkg::ST_HUNT_FIRST;
			pos_q   <= 4'd0;
		end else if (accept) begin
			state_q <= state_d;
			pos_q   <= pos_d;
		end
	end

	a_body_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == cfr_pkg::ST_BODY |-> (pos_q >= cfr_pkg::POS_LEN_HI && pos_q <= cfr_pkg::POS_CRC_LO))
		else $error("body position out of range");

	a_final_rehunts: assert property (@(posedge clk) disable iff (!arst_n)
		(push && item.op == cfr_pkg::OP_FINAL) |=> state_q == cfr_pkg::ST_HUNT_FIRST)
		else $error("frame end did not return to hunting");

endmodule

// File: sv/cfr_queue.sv
// cfr_queue: short register queue between the front and back parts
// depends on cfr_pkg for the item type
module cfr_queue #(
	parameter int DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  cfr_pkg::item_t push_item,
	output logic           full,
	input  logic           pop,
	output cfr_pkg::item_t head,
	output logic           empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cfr_pkg::item_t    mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  cnt_q;

	assign full  = (cnt_q == CNT_W'(DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + CNT_W'(1);
				2'b01:   cnt_q <= cnt_q - CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) full |-> !push)
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) empty |-> !pop)
		else $error("pop from empty queue");

endmodule

// File: sv/cfr_back.sv
// cfr_back: crc accumulation, field capture and result register of the frame receiver
// depends on cfr_pkg; drains items from cfr_queue
module cfr_back (
	input  logic               clk,
	input  logic               arst_n,
	input  cfr_pkg::item_t     head,
	input  logic               empty,
	output logic               pop,
	input  logic [15:0]        expected_length,
	input  logic [7:0]         expected_command,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               frame_ok,
	output logic signed [15:0] left_speed_rpm,
	output logic signed [15:0] right_speed_rpm,
	output logic [15:0]        length_seen,
	output logic [7:0]         command_seen,
	output logic [15:0]        crc_received,
	output logic [15:0]        crc_computed
);

	logic [15:0] crc_q, length_q, left_q, right_q;
	logic [7:0]  command_q, crc_hi_q;
	logic        out_valid_q, out_free, take_final;
	logic [15:0] crc_rx;

	logic        ok_q;
	logic [15:0] left_out_q, right_out_q, length_out_q, crc_rx_out_q, crc_out_q;
	logic [7:0]  command_out_q;

	assign out_free   = !out_valid_q || !out_stall;
	assign pop        = !empty && ((head.op != cfr_pkg::OP_FINAL) || out_free);
	assign take_final = pop && (head.op == cfr_pkg::OP_FINAL);
	assign crc_rx     = {crc_hi_q, head.data};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= cfr_pkg::CRC_INIT;
		end else if (pop) begin
			case (head.op)
				cfr_pkg::OP_START: crc_q <= cfr_pkg::crc_byte(cfr_pkg::CRC_INIT, head.data);
				cfr_pkg::OP_ADD:   crc_q <= cfr_pkg::crc_byte(crc_q, head.data);
				cfr_pkg::OP_FINAL: crc_q <= cfr_pkg::CRC_INIT;
				default:           crc_q <= crc_q;
			endcase
		end
	end

	// field capture, big-endian
	always_ff @(posedge clk) begin
		if (pop && head.op == cfr_pkg::OP_ADD) begin
			case (head.pos)
				cfr_pkg::POS_LEN_HI:   length_q[15:8] <= head.data;
				cfr_pkg::POS_LEN_LO:   length_q[7:0]  <= head.data;
				cfr_pkg::POS_COMMAND:  command_q      <= head.data;
				cfr_pkg::POS_LEFT_HI:  left_q[15:8]   <= head.data;
				cfr_pkg::POS_LEFT_LO:  left_q[7:0]    <= head.data;
				cfr_pkg::POS_RIGHT_HI: right_q[15:8]  <= head.data;
				cfr_pkg::POS_RIGHT_LO: right_q[7:0]   <= head.data;
				default: ;
			endcase
		end
		if (pop && head.op == cfr_pkg::OP_CRC_HI) begin
			crc_hi_q <= head.data;
		end
		if (take_final) begin
			ok_q          <= (length_q == expected_length) && (command_q == expected_command)
			                 && (crc_rx == crc_q);
			left_out_q    <= left_q;
			right_out_q   <= right_q;
			length_out_q  <= length_q;
			command_out_q <= command_q;
			crc_rx_out_q  <= crc_rx;
			crc_out_q     <= crc_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take_final) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid       = out_valid_q;
	assign frame_ok        = ok_q;
	assign left_speed_rpm  = $signed(left_out_q);
	assign right_speed_rpm = $signed(right_out_q);
	assign length_seen     = length_out_q;
	assign command_seen    = command_out_q;
	assign crc_received    = crc_rx_out_q;
	assign crc_computed    = crc_out_q;

	a_no_result_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |-> !take_final)
		else $error("waiting result overwritten");

endmodule

// File: sv/crc_checked_frame_receiver.sv
// crc_checked_frame_receiver: byte-stream deframer with crc-16/modbus check and apb registers
// depends on cfr_pkg, cfr_front, cfr_queue and cfr_back
// throughput: one byte per cycle while the queue is not full; one result per 11-byte frame
// a frame end passes the queue, then the result register, and waits while the queue backs up
// reset (arst_n low): hunting the first header byte, queue empty, registers at defaults
module crc_checked_frame_receiver #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	// apb configuration port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	// received byte channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         rx_byte,
	// result channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic               frame_ok,
	output logic signed [15:0] left_speed_rpm,
	output logic signed [15:0] right_speed_rpm,
	output logic [15:0]        length_seen,
	output logic [7:0]         command_seen,
	output logic [15:0]        crc_received,
	output logic [15:0]        crc_computed
);

	// configuration registers; the user writes them only while the receiver is idle, unguarded
	logic [15:0] frame_header_q;
	logic [15:0] expected_length_q;
	logic [7:0]  expected_command_q;
	logic        cfg_write;
	logic [1:0]  reg_idx;

	// front to queue
	logic           accept;
	logic           push;
	cfr_pkg::item_t push_item;
	logic           full;

	// queue to back
	logic           pop;
	logic           empty;
	cfr_pkg::item_t head;

	assign pready    = 1'b1;
	assign reg_idx   = paddr[3:2];
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_header_q     <= cfr_pkg::RST_FRAME_HEADER;
			expected_length_q  <= cfr_pkg::RST_EXPECTED_LENGTH;
			expected_command_q <= cfr_pkg::RST_EXPECTED_COMMAND;
		end else if (cfg_write) begin
			case (reg_idx)
				cfr_pkg::REG_FRAME_HEADER:     frame_header_q     <= pwdata[15:0];
				cfr_pkg::REG_EXPECTED_LENGTH:  expected_length_q  <= pwdata[15:0];
				cfr_pkg::REG_EXPECTED_COMMAND: expected_command_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// read-back, unused addresses read as zero
	always_comb begin
		case (reg_idx)
			cfr_pkg::REG_FRAME_HEADER:     prdata = {16'h0000, frame_header_q};
			cfr_pkg::REG_EXPECTED_LENGTH:  prdata = {16'h0000, expected_length_q};
			cfr_pkg::REG_EXPECTED_COMMAND: prdata = {24'h000000, expected_command_q};
			default:                       prdata = 32'h0;
		endcase
	end

	// the front stalls only when the queue has no room; the back drains
	// it independently, so a stalled result never holds up byte intake
	// until the queue fills
	assign in_stall = full;
	assign accept   = in_valid && !in_stall;

	// front: header hunt and per-byte classification (start, crc add,
	// crc high byte, frame end); bytes that fail the hunt are dropped here
	cfr_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.rx_byte      (rx_byte),
		.frame_header (frame_header_q),
		.push         (push),
		.item         (push_item)
	);

	cfr_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (full),
		.pop       (pop),
		.head      (head),
		.empty     (empty)
	);

	// back: byte-wide crc update, field capture and the result register;
	// a frame end waits in the queue while the result register holds a stalled result
	cfr_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.head             (head),
		.empty            (empty),
		.pop              (pop),
		.expected_length  (expected_length_q),
		.expected_command (expected_command_q),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.frame_ok         (frame_ok),
		.left_speed_rpm   (left_speed_rpm),
		.right_speed_rpm  (right_speed_rpm),
		.length_seen      (length_seen),
		.command_seen     (command_seen),
		.crc_received     (crc_received),
		.crc_computed     (crc_computed)
	);

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// testbench for crc_checked_frame_receiver: directed and random byte streams checked against
// a cycle-free frame predictor; needs cfr_pkg and the receiver rtl, nothing else
module testbench;

	localparam logic [15:0] MODBUS_SEED = 16'hFFFF;
	localparam logic [15:0] MODBUS_POLY = 16'hA001;
	localparam logic [1:0]  REG_UNUSED  = 2'd3;
	localparam int          DRAIN_CYCLES = 20;

	typedef enum logic [1:0] {
		ROW_RAW,
		ROW_CRC_HI,
		ROW_CRC_LO
	} row_kind_t;

	// one directed byte; crc rows take the running crc xor value
	typedef struct packed {
		row_kind_t   kind;
		logic [7:0]  value;
		logic        has_ok;
		logic        ok;
	} stim_row_t;

	typedef struct packed {
		logic        ok;
		logic [15:0] left;
		logic [15:0] right;
		logic [15:0] length;
		logic [7:0]  command;
		logic [15:0] crc_rx;
		logic [15:0] crc_want;
	} frame_result_t;

	// reset defaults: header 55 aa, length 11, command 2
	localparam stim_row_t DIRECTED_ROWS [26] = '{
		// good frame behind a repeated first header byte, speeds at both extremes
		'{ROW_RAW, 8'h55, 1'b0, 1'b0},
		'{ROW_RAW, 8'h55, 1'b0, 1'b0},
		'{ROW_RAW, 8'hAA, 1'b0, 1'b0},
		'{ROW_RAW, 8'h00, 1'b0, 1'b0},
		'{ROW_RAW, 8'h0B, 1'b0, 1'b0},
		'{ROW_RAW, 8'h02, 1'b0, 1'b0},
		'{ROW_RAW, 8'h80, 1'b0, 1'b0},
		'{ROW_RAW, 8'h00, 1'b0, 1'b0},
		'{ROW_RAW, 8'h7F, 1'b0, 1'b0},
		'{ROW_RAW, 8'hFF, 1'b0, 1'b0},
		'{ROW_CRC_HI, 8'h00, 1'b0, 1'b0},
		'{ROW_CRC_LO, 8'h00, 1'b1, 1'b1},
		// noise, broken header, then a bad frame carrying a header inside its body
		'{ROW_RAW, 8'h00, 1'b0, 1'b0},
		'{ROW_RAW, 8'h55, 1'b0, 1'b0},
		'{ROW_RAW, 8'h13, 1'b0, 1'b0},
		'{ROW_RAW, 8'h55, 1'b0, 1'b0},
		'{ROW_RAW, 8'hAA, 1'b0, 1'b0},
		'{ROW_RAW, 8'hFF, 1'b0, 1'b0},
		'{ROW_RAW, 8'hFF, 1'b0, 1'b0},
		'{ROW_RAW, 8'hFF, 1'b0, 1'b0},
		'{ROW_RAW, 8'h55, 1'b0, 1'b0},
		'{ROW_RAW, 8'hAA, 1'b0, 1'b0},
		'{ROW_RAW, 8'h00, 1'b0, 1'b0},
		'{ROW_RAW, 8'h00, 1'b0, 1'b0},
		'{ROW_CRC_HI, 8'h00, 1'b0, 1'b0},
		'{ROW_CRC_LO, 8'h01, 1'b1, 1'b0}
	};

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [3:0]         paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [7:0]         rx_byte = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic               frame_ok;
	logic signed [15:0] left_speed_rpm;
	logic signed [15:0] right_speed_rpm;
	logic [15:0]        length_seen;
	logic [7:0]         command_seen;
	logic [15:0]        crc_received;
	logic [15:0]        crc_computed;

	crc_checked_frame_receiver DUT (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.frame_ok(frame_ok),
		.left_speed_rpm(left_speed_rpm),
		.right_speed_rpm(right_speed_rpm),
		.length_seen(length_seen),
		.command_seen(command_seen),
		.crc_received(crc_received),
		.crc_computed(crc_computed)
	);

	always #5 clk = ~clk;

	// register copies
	logic [15:0] cfg_header  = cfr_pkg::RST_FRAME_HEADER;
	logic [15:0] cfg_length  = cfr_pkg::RST_EXPECTED_LENGTH;
	logic [7:0]  cfg_command = cfr_pkg::RST_EXPECTED_COMMAND;

	// deframer state as the block should hold it
	cfr_pkg::front_state_t pr_phase = cfr_pkg::ST_HUNT_FIRST;
	logic [3:0]   pr_pos = '0;
	logic [15:0]  pr_crc = MODBUS_SEED;
	logic [15:0]  pr_len = '0;
	logic [7:0]   pr_cmd = '0;
	logic [15:0]  pr_left = '0;
	logic [15:0]  pr_right = '0;
	logic [7:0]   pr_crc_hi = '0;

	frame_result_t pending_frames[$];
	int in_idle_pct = 0;
	int out_idle_pct = 0;
	int out_stall_left = 0;
	int mismatch_count = 0;
	int bytes_sent = 0;
	int frames_checked = 0;
	int good_frames = 0;

	// bit-serial form of crc-16/modbus, lsb first
	function automatic logic [15:0] modbus_crc_update(input logic [15:0] crc, input logic [7:0] d);
		logic [15:0] c;
		logic        fb;
		c = crc;
		for (int i = 0; i < 8; i++) begin
			fb = c[0] ^ d[i];
			c = c >> 1;
			if (fb) begin
				c = c ^ MODBUS_POLY;
			end
		end
		return c;
	endfunction

	task automatic deframe_byte(input logic [7:0] b, output bit done, output frame_result_t res);
		logic [7:0]  hdr_hi;
		logic [7:0]  hdr_lo;
		logic [15:0] rx_crc;
		hdr_hi = cfg_header[15:8];
		hdr_lo = cfg_header[7:0];
		done = 1'b0;
		res = '0;
		if (pr_phase == cfr_pkg::ST_HUNT_SECOND && b == hdr_lo) begin
			pr_crc = modbus_crc_update(pr_crc, b);
			pr_phase = cfr_pkg::ST_BODY;
			pr_pos = cfr_pkg::POS_LEN_HI;
		end else if (pr_phase != cfr_pkg::ST_BODY) begin
			// first header byte, also a restart while hunting the second one
			if (b == hdr_hi) begin
				pr_phase = cfr_pkg::ST_HUNT_SECOND;
				pr_pos = cfr_pkg::POS_HEADER_LO;
				pr_crc = modbus_crc_update(MODBUS_SEED, b);
			end else begin
				pr_phase = cfr_pkg::ST_HUNT_FIRST;
				pr_pos = '0;
				pr_crc = MODBUS_SEED;
			end
		end else if (pr_pos < cfr_pkg::POS_CRC_HI) begin
			pr_crc = modbus_crc_update(pr_crc, b);
			case (pr_pos)
				cfr_pkg::POS_LEN_HI:   pr_len[15:8] = b;
				cfr_pkg::POS_LEN_LO:   pr_len[7:0] = b;
				cfr_pkg::POS_COMMAND:  pr_cmd = b;
				cfr_pkg::POS_LEFT_HI:  pr_left[15:8] = b;
				cfr_pkg::POS_LEFT_LO:  pr_left[7:0] = b;
				cfr_pkg::POS_RIGHT_HI: pr_right[15:8] = b;
				default:               pr_right[7:0] = b;
			endcase
			pr_pos = pr_pos + 4'd1;
		end else if (pr_pos == cfr_pkg::POS_CRC_HI) begin
			pr_crc_hi = b;
			pr_pos = pr_pos + 4'd1;
		end else begin
			rx_crc = {pr_crc_hi, b};
			res.ok = (pr_len == cfg_length) && (pr_cmd == cfg_command) && (rx_crc == pr_crc);
			res.left = pr_left;
			res.right = pr_right;
			res.length = pr_len;
			res.command = pr_cmd;
			res.crc_rx = rx_crc;
			res.crc_want = pr_crc;
			done = 1'b1;
			pr_phase = cfr_pkg::ST_HUNT_FIRST;
			pr_pos = '0;
			pr_crc = MODBUS_SEED;
		end
	endtask

	task automatic report(input string what);
		mismatch_count++;
		$display("%0t: %s", $time, what);
	endtask

	// drive one byte, wait for it to be taken, then advance the predictor
	task automatic send_byte(input logic [7:0] b, input bit typed_en, input bit typed_ok);
		bit            done;
		frame_result_t res;
		if (in_idle_pct > 0 && $urandom_range(0, 99) < in_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (in_stall);
		bytes_sent++;
		deframe_byte(b, done, res);
		if (done) begin
			if (typed_en) begin
				res.ok = typed_ok;
			end
			pending_frames.push_back(res);
		end else if (typed_en) begin
			report("directed row did not close a frame");
		end
	endtask

	// lower valid and let the block run dry
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_frames.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apb_xfer(input bit wr, input logic [1:0] idx, input logic [31:0] wdata,
			output logic [31:0] rdata);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	function automatic logic [31:0] reg_mirror(input logic [1:0] idx);
		case (idx)
			cfr_pkg::REG_FRAME_HEADER:     return {16'h0, cfg_header};
			cfr_pkg::REG_EXPECTED_LENGTH:  return {16'h0, cfg_length};
			cfr_pkg::REG_EXPECTED_COMMAND: return {24'h0, cfg_command};
			default:                       return '0;
		endcase
	endfunction

	task automatic verify_reg(input logic [1:0] idx);
		logic [31:0] rd;
		apb_xfer(1'b0, idx, '0, rd);
		if (rd !== reg_mirror(idx)) begin
			report($sformatf("register %0d readback expected %h got %h", idx, reg_mirror(idx), rd));
		end
	endtask

	task automatic program_reg(input logic [1:0] idx, input logic [31:0] data);
		logic [31:0] unused_rd;
		apb_xfer(1'b1, idx, data, unused_rd);
		case (idx)
			cfr_pkg::REG_FRAME_HEADER:     cfg_header = data[15:0];
			cfr_pkg::REG_EXPECTED_LENGTH:  cfg_length = data[15:0];
			cfr_pkg::REG_EXPECTED_COMMAND: cfg_command = data[7:0];
			default: ;
		endcase
		if (idx == REG_UNUSED) begin
			// a write to the spare slot must leave the real registers alone
			verify_reg(cfr_pkg::REG_FRAME_HEADER);
			verify_reg(cfr_pkg::REG_EXPECTED_LENGTH);
			verify_reg(cfr_pkg::REG_EXPECTED_COMMAND);
		end else begin
			verify_reg(idx);
		end
	endtask

	task automatic set_config(input logic [15:0] hdr, input logic [15:0] len, input logic [7:0] cmd);
		wait_idle();
		program_reg(cfr_pkg::REG_FRAME_HEADER, {16'($urandom_range(0, 65535)), hdr});
		program_reg(cfr_pkg::REG_EXPECTED_LENGTH, {16'($urandom_range(0, 65535)), len});
		program_reg(cfr_pkg::REG_EXPECTED_COMMAND,
			{16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)), cmd});
	endtask

	function automatic logic [15:0] pick_speed();
		logic [15:0] corners [4] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};
		if ($urandom_range(0, 99) < 20) begin
			return corners[2'($urandom_range(0, 3))];
		end
		return 16'($urandom_range(0, 65535));
	endfunction

	// mostly well-formed frames with random content, some noise and bad fields
	task automatic send_random_frame();
		logic [7:0]  content [0:8];
		logic [15:0] len_v;
		logic [15:0] left_v;
		logic [15:0] right_v;
		logic [7:0]  xor_hi;
		logic [7:0]  xor_lo;
		int          r;
		r = $urandom_range(0, 99);
		if (r < 20) begin
			repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
		end else if (r < 30) begin
			// header that breaks after its first byte
			send_byte(cfg_header[15:8], 1'b0, 1'b0);
			send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
		end else if (r < 38) begin
			send_byte(cfg_header[15:8], 1'b0, 1'b0);
		end
		len_v = ($urandom_range(0, 99) < 85) ? cfg_length : 16'($urandom_range(0, 65535));
		left_v = pick_speed();
		right_v = pick_speed();
		content[0] = cfg_header[15:8];
		content[1] = cfg_header[7:0];
		content[cfr_pkg::POS_LEN_HI] = len_v[15:8];
		content[cfr_pkg::POS_LEN_LO] = len_v[7:0];
		content[cfr_pkg::POS_COMMAND] = ($urandom_range(0, 99) < 85) ? cfg_command :
			8'($urandom_range(0, 255));
		content[cfr_pkg::POS_LEFT_HI] = left_v[15:8];
		content[cfr_pkg::POS_LEFT_LO] = left_v[7:0];
		content[cfr_pkg::POS_RIGHT_HI] = right_v[15:8];
		content[cfr_pkg::POS_RIGHT_LO] = right_v[7:0];
		xor_hi = '0;
		xor_lo = '0;
		if ($urandom_range(0, 99) < 15) begin
			xor_hi = 8'($urandom_range(0, 255));
			xor_lo = 8'($urandom_range(0, 255));
			if (xor_hi == 0 && xor_lo == 0) begin
				xor_lo = 8'h01;
			end
		end
		// steer by the predicted state so the frame lines up after any noise
		while (pr_phase != cfr_pkg::ST_BODY) begin
			send_byte((pr_phase == cfr_pkg::ST_HUNT_SECOND) ? content[1] : content[0],
				1'b0, 1'b0);
		end
		while (pr_pos <= cfr_pkg::POS_RIGHT_LO) send_byte(content[pr_pos], 1'b0, 1'b0);
		if (pr_pos == cfr_pkg::POS_CRC_HI) begin
			send_byte(pr_crc[15:8] ^ xor_hi, 1'b0, 1'b0);
		end
		send_byte(pr_crc[7:0] ^ xor_lo, 1'b0, 1'b0);
	endtask

	task automatic run_random(input int n_bytes, input int in_pct, input int out_pct);
		int stop_at;
		in_idle_pct = in_pct;
		out_idle_pct = out_pct;
		stop_at = bytes_sent + n_bytes;
		while (bytes_sent < stop_at) send_random_frame();
	endtask

	task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
		if (want !== got) begin
			report($sformatf("%s expected %h got %h", name, want, got));
		end
	endtask

	// result side: random stall bursts, every taken result checked against the oldest frame
	initial begin
		frame_result_t want;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				if (pending_frames.size() == 0) begin
					report($sformatf("unexpected result ok %b len %h cmd %h crc %h/%h",
						frame_ok, length_seen, command_seen, crc_received, crc_computed));
				end else begin
					want = pending_frames.pop_front();
					frames_checked++;
					if (want.ok) begin
						good_frames++;
					end
					check_field("frame_ok", 16'(want.ok), 16'(frame_ok));
					check_field("left_speed_rpm", want.left, left_speed_rpm);
					check_field("right_speed_rpm", want.right, right_speed_rpm);
					check_field("length_seen", want.length, length_seen);
					check_field("command_seen", 16'(want.command), 16'(command_seen));
					check_field("crc_received", want.crc_rx, crc_received);
					check_field("crc_computed", want.crc_want, crc_computed);
				end
			end
			if (out_stall_left > 0) begin
				out_stall_left--;
			end else if (out_idle_pct > 0 && $urandom_range(0, 99) < out_idle_pct) begin
				out_stall <= 1'b1;
				out_stall_left = $urandom_range(0, 14);
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// hard stop well past the slowest legal run
	initial begin
		#5_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		stim_row_t row;
		logic [7:0] b;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// registers must read back their reset values
		verify_reg(cfr_pkg::REG_FRAME_HEADER);
		verify_reg(cfr_pkg::REG_EXPECTED_LENGTH);
		verify_reg(cfr_pkg::REG_EXPECTED_COMMAND);

		in_idle_pct = 30;
		out_idle_pct = 30;
		for (int i = 0; i < $size(DIRECTED_ROWS); i++) begin
			row = DIRECTED_ROWS[i];
			case (row.kind)
				ROW_CRC_HI: b = pr_crc[15:8] ^ row.value;
				ROW_CRC_LO: b = pr_crc[7:0] ^ row.value;
				default:    b = row.value;
			endcase
			send_byte(b, row.has_ok, row.ok);
		end

		run_random(260, 30, 30);
		set_config(16'hFFFF, 16'hFFFF, 8'hFF);
		run_random(270, 0, 0);
		set_config(16'h0000, 16'h0000, 8'h00);
		run_random(270, 50, 10);
		set_config(16'h5555, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
		run_random(270, 10, 60);
		set_config(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
			8'($urandom_range(0, 255)));
		run_random(270, 25, 25);
		wait_idle();
		program_reg(REG_UNUSED, $urandom());
		set_config(cfr_pkg::RST_FRAME_HEADER, cfr_pkg::RST_EXPECTED_LENGTH,
			8'($urandom_range(0, 255)));
		run_random(280, 0, 0);
		wait_idle();

		$display("run covered %0d bytes and %0d frames (%0d good, %0d rejected)",
			bytes_sent, frames_checked, good_frames, frames_checked - good_frames);
		$display("over six register settings with both header extremes and equal header bytes");
		if (mismatch_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// File: files.f
sv/cfr_pkg.sv
sv/cfr_front.sv
sv/cfr_queue.sv
sv/cfr_back.sv
sv/crc_checked_frame_receiver.sv
sim/testbench.sv
